// ===== hdl/ordered_dispatch_queue_with_barriers_macros.svh =====
// Assertion macros shared by the dispatch queue RTL
`ifndef ORDERED_DISPATCH_QUEUE_WITH_BARRIERS_MACROS_SVH
`define ORDERED_DISPATCH_QUEUE_WITH_BARRIERS_MACROS_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante
`define ODQ_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("odq assertion failed");

// Check that cons holds in the cycle after ante
`define ODQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("odq assertion failed");

`else

`define ODQ_ASSERT_NOW(label, clk, rst, ante, cons)
`define ODQ_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/odq_pkg.sv =====
// Shared codes and types for the ordered dispatch queue
package odq_pkg;

  localparam logic [1:0] ACT_ENQ_OP  = 2'd0;
  localparam logic [1:0] ACT_ENQ_BAR = 2'd1;
  localparam logic [1:0] ACT_DONE    = 2'd2;
  localparam logic [1:0] ACT_CLOSE   = 2'd3;

  localparam logic [1:0] EV_ACK   = 2'd0;
  localparam logic [1:0] EV_START = 2'd1;
  localparam logic [1:0] EV_FIRE  = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_CLOSED   = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_MISMATCH = 3'd3;
  localparam logic [2:0] ST_IGNORED  = 3'd4;

  typedef struct packed {
    logic push;
    logic pop;
  } odq_chain_ctl_t;

endpackage

// ===== hdl/ordered_dispatch_queue_with_barriers.sv =====
// Top level of the ordered dispatch queue with barriers
//
// Command channel (cmd_valid/cmd_ready): each word carries an action
// (enqueue operation, enqueue barrier, done, close), a tag and close_after.
// Result channel (res_valid/res_ready): each word carries one event
// (acknowledge, start operation, fire barrier) with the queue status after it;
// last marks the final word caused by a command.
// Every command first yields its acknowledge, registered on the cycle of
// acceptance and visible in the following cycle. After a push or a pop,
// when nothing runs, the head of the chain is walked one entry per cycle
// while the result register is free: each barrier gives a fire word, the
// first operation a start word. A command thus yields its acknowledge plus
// one word per walked entry; the walk is set by the single head slot
// of the entry chain, which shifts by one slot per pop.
// A new command is taken once the previous command's words are all produced
// and the result register is free or being read.
// A stalled receiver holds the result register and thereby pauses the walk.
// Reset empties the queue, clears the running and closed flags and drops any
// pending result word; the entry slots themselves are not cleared.
module ordered_dispatch_queue_with_barriers #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 8,
  localparam int CW         = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  logic [1:0]          action,
  input  logic [TAG_BITS-1:0] item_tag,
  input  logic                close_after,
  output logic                res_valid,
  input  logic                res_ready,
  output logic [1:0]          event_res,
  output logic [2:0]          status,
  output logic [TAG_BITS-1:0] out_tag,
  output logic                last,
  output logic [CW-1:0]       queued,
  output logic                busy_res,
  output logic                is_shut
);
  import odq_pkg::*;

  odq_chain_ctl_t    ctl;
  logic [CW-1:0]     count;
  logic [TAG_BITS:0] push_entry;
  logic [TAG_BITS:0] entries [QUEUE_DEPTH];

  odq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS),
    .CW          (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .action      (action),
    .item_tag    (item_tag),
    .close_after (close_after),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .event_res   (event_res),
    .status      (status),
    .out_tag     (out_tag),
    .last        (last),
    .queued      (queued),
    .busy_res    (busy_res),
    .is_shut     (is_shut),
    .head_entry  (entries[0]),
    .ctl         (ctl),
    .count       (count),
    .push_entry  (push_entry)
  );

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [TAG_BITS:0] up_entry;
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign up_entry = '0;
    end else begin : g_body
      assign up_entry = entries[i+1];
    end
    odq_cell #(
      .TAG_BITS (TAG_BITS),
      .CW       (CW),
      .INDEX    (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .wr_idx     (count),
      .push_entry (push_entry),
      .up_entry   (up_entry),
      .entry      (entries[i])
    );
  end

endmodule

// ===== hdl/odq_cell.sv =====
// One slot of the shifting entry chain; slot 0 is the queue head
module odq_cell #(
  parameter int TAG_BITS = 8,
  parameter int CW       = 5,
  parameter int INDEX    = 0
) (
  input  logic                    clk,
  input  odq_pkg::odq_chain_ctl_t ctl,
  input  logic [CW-1:0]           wr_idx,
  input  logic [TAG_BITS:0]       push_entry,
  input  logic [TAG_BITS:0]       up_entry,
  output logic [TAG_BITS:0]       entry
);
  import odq_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      // advance towards the head
      entry <= up_entry;
    end else if (ctl.push && wr_idx == CW'(INDEX)) begin
      entry <= push_entry;
    end
  end

endmodule

// ===== hdl/odq_ctrl.sv =====
// Command decode, drain sequencer and result register of the dispatch queue
`include "ordered_dispatch_queue_with_barriers_macros.svh"

module odq_ctrl #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 8,
  parameter int CW          = 5
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cmd_valid,
  output logic                    cmd_ready,
  input  logic [1:0]              action,
  input  logic [TAG_BITS-1:0]     item_tag,
  input  logic                    close_after,
  output logic                    res_valid,
  input  logic                    res_ready,
  output logic [1:0]              event_res,
  output logic [2:0]              status,
  output logic [TAG_BITS-1:0]     out_tag,
  output logic                    last,
  output logic [CW-1:0]           queued,
  output logic                    busy_res,
  output logic                    is_shut,
  input  logic [TAG_BITS:0]       head_entry,
  output odq_pkg::odq_chain_ctl_t ctl,
  output logic [CW-1:0]           count,
  output logic [TAG_BITS:0]       push_entry
);
  import odq_pkg::*;

  typedef enum logic {S_IDLE, S_DRAIN} state_t;

  state_t              state, state_next;
  logic                busy, busy_next;
  logic                closed, closed_next;
  logic [CW-1:0]       count_next;
  logic                out_free, take, load;
  logic [1:0]          ev_next;
  logic [2:0]          st_next;
  logic [TAG_BITS-1:0] tag_next;
  logic                last_next;
  logic                head_kind;
  logic [TAG_BITS-1:0] head_tag;

  assign head_kind  = head_entry[TAG_BITS];
  assign head_tag   = head_entry[TAG_BITS-1:0];
  assign out_free   = !res_valid || res_ready;
  assign cmd_ready  = (state == S_IDLE) && out_free;
  assign take       = cmd_valid && cmd_ready;
  assign push_entry = {action == ACT_ENQ_BAR, item_tag};

  always_comb begin
    state_next  = state;
    busy_next   = busy;
    closed_next = closed;
    count_next  = count;
    ctl         = '0;
    load        = 1'b0;
    ev_next     = EV_ACK;
    st_next     = ST_OK;
    tag_next    = '0;
    last_next   = 1'b1;
    if (take) begin
      load = 1'b1;
      unique case (action)
        ACT_ENQ_OP, ACT_ENQ_BAR: begin
          if (closed) begin
            st_next = ST_CLOSED;
          end else if (count == CW'(QUEUE_DEPTH)) begin
            st_next = ST_FULL;
          end else begin
            ctl.push    = 1'b1;
            count_next  = count + CW'(1);
            closed_next = closed | ((action == ACT_ENQ_BAR) & close_after);
          end
        end
        ACT_DONE: begin
          if (!busy || count == '0) begin
            st_next = ST_IGNORED;
          end else if (head_kind || head_tag != item_tag) begin
            st_next = ST_MISMATCH;
          end else begin
            ctl.pop    = 1'b1;
            count_next = count - CW'(1);
            busy_next  = 1'b0;
          end
        end
        ACT_CLOSE: begin
          closed_next = 1'b1;
        end
        default: ;
      endcase
      // walk the head in following cycles when nothing runs
      if ((ctl.push || ctl.pop) && !busy_next && count_next != '0) begin
        last_next  = 1'b0;
        state_next = S_DRAIN;
      end
    end else if (state == S_DRAIN && out_free) begin
      load     = 1'b1;
      tag_next = head_tag;
      if (head_kind) begin
        ctl.pop    = 1'b1;
        count_next = count - CW'(1);
        ev_next    = EV_FIRE;
        last_next  = (count_next == '0);
      end else begin
        busy_next = 1'b1;
        ev_next   = EV_START;
        last_next = 1'b1;
      end
      if (last_next) begin
        state_next = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      busy      <= 1'b0;
      closed    <= 1'b0;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state  <= state_next;
      busy   <= busy_next;
      closed <= closed_next;
      count  <= count_next;
      if (load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
    if (load) begin
      event_res <= ev_next;
      status    <= st_next;
      out_tag   <= tag_next;
      last      <= last_next;
      queued    <= count_next;
      busy_res  <= busy_next;
      is_shut   <= closed_next;
    end
  end

  `ODQ_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CW'(QUEUE_DEPTH))
  `ODQ_ASSERT_NOW(a_busy_has_head, clk, rst, busy, count != '0)
  `ODQ_ASSERT_NOW(a_push_pop_excl, clk, rst, ctl.push, !ctl.pop)
  `ODQ_ASSERT_NEXT(a_start_sets_busy, clk, rst,
                   load && ev_next == EV_START, busy && state == S_IDLE)
  `ODQ_ASSERT_NOW(a_drain_not_busy, clk, rst, state == S_DRAIN, !busy && count != '0)

endmodule
